FILE: hw/rtl/falc_pkg.sv
// Shared constants and types for the fully associative LRU cache.
package falc_pkg;

  localparam int LinesDef     = 8;
  localparam int LineWordsDef = 8;
  localparam int AddrBitsDef  = 12;
  localparam int BytesPerWord = 4;
  localparam int DataW        = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/fully_associative_lru_cache.sv
// Fully associative write-through cache with LRU replacement: top level.
//
// Each request is one word read or write. A hit goes from start through LOOKUP
// to the out_valid strobe in DONE; a miss also passes through FILL, streaming
// the line word by word through the one read port of the backing memory. busy
// stays high through the result strobe, and the result is shown for one cycle
// only, since the receiver cannot stall. After reset a clearing pass zeroes the
// backing memory, one word a cycle, with busy high.
module fully_associative_lru_cache #(
  parameter int LINES      = falc_pkg::LinesDef,
  parameter int LINE_WORDS = falc_pkg::LineWordsDef,
  parameter int ADDR_BITS  = falc_pkg::AddrBitsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ADDR_BITS-1:0]       in_address,
  input  logic [falc_pkg::DataW-1:0] in_write_data,
  input  logic                       in_write_enable,
  output logic                       out_valid,
  output logic [falc_pkg::DataW-1:0] out_read_data,
  output logic                       out_hit,
  output logic [falc_pkg::DataW-1:0] out_hit_total,
  output logic [falc_pkg::DataW-1:0] out_miss_total
);
  import falc_pkg::*;

  localparam int WaW   = ADDR_BITS - 2;
  localparam int MemW  = 1 << WaW;
  localparam int OffW  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int LnW   = $clog2(LINES);
  localparam int TagW  = (WaW - $clog2(LINE_WORDS) > 0) ? WaW - $clog2(LINE_WORDS) : 1;
  localparam int LwW   = $clog2(LINES * LINE_WORDS) > 0 ? $clog2(LINES * LINE_WORDS) : 1;
  localparam int CntW  = $clog2(LINE_WORDS + 1);

  // Memories
  logic [DataW-1:0] back_mem [MemW];
  logic [DataW-1:0] line_mem [LINES*LINE_WORDS];

  state_t state_r, state_nxt;
  logic [WaW:0]       clr_r;
  logic [WaW-1:0]     word_r;
  logic [DataW-1:0]   wdata_r;
  logic               we_r;
  logic [LINES-1:0]   valid_r;
  logic [TagW-1:0]    tag_r [LINES];
  logic [LnW-1:0]     rank_r [LINES];
  logic [LnW-1:0]     line_r;
  logic               hit_r;
  logic [CntW-1:0]    fcnt_r;
  logic [DataW-1:0]   hits_r, misses_r;
  logic [DataW-1:0]   back_q, line_q;

  logic [TagW-1:0]    req_tag;
  logic [OffW-1:0]    req_off;
  logic               look_hit;
  logic [LnW-1:0]     look_line, victim;
  logic               any_inv;

  assign req_tag = TagW'(word_r >> $clog2(LINE_WORDS));
  assign req_off = OffW'(word_r % LINE_WORDS);

  // Tag match and victim search over the line registers
  always_comb begin
    look_hit  = 1'b0;
    look_line = '0;
    any_inv   = 1'b0;
    victim    = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == req_tag) begin
        look_hit  = 1'b1;
        look_line = LnW'(i);
      end
      if (!valid_r[i]) begin
        any_inv = 1'b1;
        victim  = LnW'(i);
      end
    end
    if (!any_inv) begin
      for (int i = 0; i < LINES; i++) begin
        if (rank_r[i] == LnW'(LINES - 1)) victim = LnW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == (WaW+1)'(MemW - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = look_hit ? ST_DONE : ST_FILL;
      ST_FILL:   if (fcnt_r == CntW'(LINE_WORDS)) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end
  assign out_read_data  = line_q;
  assign out_hit        = hit_r;
  assign out_hit_total  = hits_r;
  assign out_miss_total = misses_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      valid_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      fcnt_r   <= '0;
      for (int i = 0; i < LINES; i++) begin
        tag_r[i]  <= '0;
        rank_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_IDLE && start) fcnt_r <= '0;
      if (state_r == ST_FILL) fcnt_r <= fcnt_r + 1'b1;
      if (state_r == ST_LOOKUP) begin
        // touch the used line and age the younger ones
        logic [LnW-1:0] used;
        logic [LnW:0]   old_age;
        used    = look_hit ? look_line : victim;
        old_age = valid_r[used] ? {1'b0, rank_r[used]} : (LnW+1)'(LINES);
        for (int i = 0; i < LINES; i++) begin
          if (LnW'(i) != used && valid_r[i] && {1'b0, rank_r[i]} < old_age)
            rank_r[i] <= rank_r[i] + 1'b1;
        end
        rank_r[used]  <= '0;
        valid_r[used] <= 1'b1;
        tag_r[used]   <= req_tag;
        if (look_hit) hits_r <= hits_r + 1'b1;
        else misses_r <= misses_r + 1'b1;
      end
    end
  end

  // Request payload and lookup result
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      word_r  <= in_address[ADDR_BITS-1:2];
      wdata_r <= in_write_data;
      we_r    <= in_write_enable;
    end
    if (state_r == ST_LOOKUP) begin
      hit_r  <= look_hit;
      line_r <= look_hit ? look_line : victim;
    end
  end

  // Backing memory: clear, write through, fill reads
  logic [WaW-1:0] fill_addr;
  assign fill_addr = WaW'({req_tag, {$clog2(LINE_WORDS){1'b0}}} | WaW'(fcnt_r));
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) back_mem[clr_r[WaW-1:0]] <= '0;
    else if (state_r == ST_LOOKUP && we_r) back_mem[word_r] <= wdata_r;
    back_q <= back_mem[fill_addr];
  end

  // Line memory: fill, write hit, result read
  logic [LwW-1:0] fill_dst, rd_idx;
  logic [OffW-1:0] fill_off;
  assign fill_off = OffW'(fcnt_r - 1'b1);
  assign fill_dst = LwW'(line_r * LINE_WORDS + fill_off);
  assign rd_idx   = LwW'((state_r == ST_LOOKUP ? look_line : line_r) * LINE_WORDS + req_off);
  always_ff @(posedge clk) begin
    if (state_r == ST_FILL && fcnt_r != '0) begin
      // forward the fresh write over the backing read word
      line_mem[fill_dst] <= (we_r && fill_off == req_off) ? wdata_r : back_q;
    end else if (state_r == ST_LOOKUP && look_hit && we_r) begin
      line_mem[rd_idx] <= wdata_r;
    end
    if (state_r == ST_LOOKUP && look_hit && we_r) line_q <= wdata_r;
    else if (state_r == ST_FILL && fcnt_r != '0 && fill_off == req_off)
      line_q <= we_r ? wdata_r : back_q;
    else if (state_r == ST_LOOKUP) line_q <= line_mem[rd_idx];
  end

endmodule
